### rtl/bqc_pkg.sv
// ----------------------------------------------------------------------------
// bqc_pkg : shared types and constants of the biquad cascade core
// Opcodes, coefficient slots, the control word and the microprogram ROM.
// ----------------------------------------------------------------------------
package bqc_pkg;

  localparam int COEF_W        = 20;   // coefficient width
  localparam int VAL_W         = 40;   // delay and inter-section value width
  localparam int ACC_W         = 64;   // full-precision accumulator
  localparam int HALF_W        = 20;   // operand half fed to the multiplier
  localparam int PROD_W        = COEF_W + HALF_W + 1;
  localparam int DLY_FRAC      = 16;   // fraction bits of values
  localparam int SAMPLE_W      = 16;
  localparam int COEFS_PER_SEC = 5;
  localparam int PC_W          = 5;

  localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
  localparam logic [PC_W-1:0] PC_SEC  = 5'd1;
  localparam logic [PC_W-1:0] PC_EMIT = 5'd16;

  localparam logic [2:0] REG_ADDR_SECTIONS = 3'd0;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_COEF   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    SLOT_B0 = 3'd0,
    SLOT_B1 = 3'd1,
    SLOT_B2 = 3'd2,
    SLOT_A1 = 3'd3,
    SLOT_A2 = 3'd4
  } slot_e;

  typedef enum logic [1:0] {
    SRC_W0 = 2'd0,
    SRC_W1 = 2'd1,
    SRC_W2 = 2'd2
  } src_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_CLR  = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_e;

  typedef enum logic [1:0] {
    SEQ_NEXT = 2'd0,   // fall through to the next step
    SEQ_WAIT = 2'd1,   // idle, take an input beat
    SEQ_LOOP = 2'd2,   // end of section: next section or emit
    SEQ_EMIT = 2'd3    // load the output register when it is free
  } seq_e;

  typedef struct packed {
    logic  dly_rd;
    logic  coef_rd;
    slot_e coef_slot;
    logic  mul_en;
    src_e  mul_src;
    logic  mul_hi;
    acc_e  acc_op;
    logic  set_w0;
    logic  set_v;
    seq_e  seq;
  } ctrl_t;

  // Microprogram for one section. Each coefficient read is issued ahead of
  // its first use, at latest in the step before it; each product is split
  // into a low and a high half, accumulated in the step after it is formed.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c           = '0;
    c.coef_slot = SLOT_B0;
    c.mul_src   = SRC_W0;
    c.acc_op    = ACC_HOLD;
    c.seq       = SEQ_NEXT;
    unique case (pc)
      PC_IDLE: c.seq = SEQ_WAIT;
      5'd1: begin
        c.dly_rd = 1'b1; c.coef_rd = 1'b1; c.coef_slot = SLOT_A1;
        c.acc_op = ACC_CLR;
      end
      5'd2: begin
        c.mul_en = 1'b1; c.mul_src = SRC_W1;
      end
      5'd3: begin
        c.mul_en = 1'b1; c.mul_src = SRC_W1; c.mul_hi = 1'b1;
        c.acc_op = ACC_SUB; c.coef_rd = 1'b1; c.coef_slot = SLOT_A2;
      end
      5'd4: begin
        c.mul_en = 1'b1; c.mul_src = SRC_W2; c.acc_op = ACC_SUB;
      end
      5'd5: begin
        c.mul_en = 1'b1; c.mul_src = SRC_W2; c.mul_hi = 1'b1;
        c.acc_op = ACC_SUB; c.coef_rd = 1'b1; c.coef_slot = SLOT_B0;
      end
      5'd6: c.acc_op = ACC_SUB;
      5'd7: begin
        c.set_w0 = 1'b1; c.acc_op = ACC_CLR;
      end
      5'd8: begin
        c.mul_en = 1'b1; c.mul_src = SRC_W0;
      end
      5'd9: begin
        c.mul_en = 1'b1; c.mul_src = SRC_W0; c.mul_hi = 1'b1;
        c.acc_op = ACC_ADD; c.coef_rd = 1'b1; c.coef_slot = SLOT_B1;
      end
      5'd10: begin
        c.mul_en = 1'b1; c.mul_src = SRC_W1; c.acc_op = ACC_ADD;
      end
      5'd11: begin
        c.mul_en = 1'b1; c.mul_src = SRC_W1; c.mul_hi = 1'b1;
        c.acc_op = ACC_ADD; c.coef_rd = 1'b1; c.coef_slot = SLOT_B2;
      end
      5'd12: begin
        c.mul_en = 1'b1; c.mul_src = SRC_W2; c.acc_op = ACC_ADD;
      end
      5'd13: begin
        c.mul_en = 1'b1; c.mul_src = SRC_W2; c.mul_hi = 1'b1;
        c.acc_op = ACC_ADD;
      end
      5'd14: c.acc_op = ACC_ADD;
      5'd15: begin
        c.set_v = 1'b1; c.seq = SEQ_LOOP;
      end
      PC_EMIT: c.seq = SEQ_EMIT;
      default: c.seq = SEQ_WAIT;
    endcase
    return c;
  endfunction

  // Clamp a wide signed value to the 40-bit value range.
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] x);
    logic top_ones;
    logic top_zeros;
    top_ones  = &x[ACC_W-1:VAL_W-1];
    top_zeros = ~(|x[ACC_W-1:VAL_W-1]);
    if (top_ones || top_zeros) begin
      return x[VAL_W-1:0];
    end else if (x[ACC_W-1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

endpackage

### rtl/biquad_cascade_iir_filter_core.sv
// ----------------------------------------------------------------------------
// biquad_cascade_iir_filter_core : cascaded direct form II biquad filter
// Microcoded sequencer driving one shared 20x21 multiplier and accumulator.
// ----------------------------------------------------------------------------
// Usage
//   Input beats arrive on s_axis; tuser carries the opcode: plain sample,
//   sample after clearing all section delays, or coefficient write. A
//   coefficient write is absorbed in the accept cycle and returns nothing;
//   opcode 3 is dropped. Each sample gives one beat on m_axis.
//   The APB port holds sections_in_use at address 0 (0 acts as 1, values
//   above MAX_SECTIONS act as MAX_SECTIONS); write it only while idle.
// Sequencing
//   A sample runs through the microprogram once per active section, at
//   most one multiplier half-product per step, after an accept step and
//   before an emit step; the next sample is taken only after the result
//   has been loaded into the output register.
// Reset
//   sections_in_use returns to 1 and every delay reads as zero through
//   per-section valid bits. Coefficients hold nothing until written.
// Stall
//   The result sits in an output register; while it waits the core keeps
//   running the next sample and only holds in its emit step.
// ----------------------------------------------------------------------------
module biquad_cascade_iir_filter_core
  import bqc_pkg::*;
#(
  parameter int MAX_SECTIONS   = 8,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] sample_in, [18:16] coef_section, [21:19] coef_slot,
  // [41:22] coef_value, [47:42] zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] sample_out
  output logic [15:0] m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SEC_W   = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CDEPTH  = MAX_SECTIONS * COEFS_PER_SEC;
  localparam int CA_W    = $clog2(CDEPTH);
  localparam int ROW_W   = 2 * VAL_W;

  // ---- input fields
  opcode_e                   in_op;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [2:0]                in_csec;
  logic [2:0]                in_cslot;
  logic signed [COEF_W-1:0]  in_cval;

  assign in_op     = opcode_e'(s_axis_tuser);
  assign in_sample = s_axis_tdata[15:0];
  assign in_csec   = s_axis_tdata[18:16];
  assign in_cslot  = s_axis_tdata[21:19];
  assign in_cval   = s_axis_tdata[41:22];

  // ---- control state
  logic [PC_W-1:0]         pc_q, pc_d;
  logic [SEC_W-1:0]        sec_q, sec_d;
  logic [SEC_W-1:0]        last_q, last_d;
  logic [3:0]              sections_q, sections_d;
  logic [MAX_SECTIONS-1:0] dvalid_q, dvalid_d;
  logic                    rd_valid_q;
  logic                    out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]     out_data_q;

  // ---- datapath registers
  logic signed [VAL_W-1:0]  v_q;
  logic signed [VAL_W-1:0]  w0_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_hi_q;
  logic signed [COEF_W-1:0] cdat_q;
  logic [ROW_W-1:0]         drow_q;

  logic [ROW_W-1:0]         dly_mem [MAX_SECTIONS];
  logic signed [COEF_W-1:0] coef_mem [CDEPTH];

  ctrl_t ctrl;
  assign ctrl = ucode(pc_q);

  logic in_fire, is_sample, coef_ok, cfg_wr, emit_go;
  assign s_axis_tready = (ctrl.seq == SEQ_WAIT);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_sample     = (in_op == OP_SAMPLE) || (in_op == OP_CLEAR);
  assign coef_ok       = (32'(in_cslot) < COEFS_PER_SEC) && (32'(in_csec) < MAX_SECTIONS);
  assign cfg_wr        = psel && penable && pwrite && pready && (paddr == REG_ADDR_SECTIONS);
  assign emit_go       = (ctrl.seq == SEQ_EMIT) && (!out_valid_q || m_axis_tready);

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ADDR_SECTIONS) ? {28'd0, sections_q} : 32'd0;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---- clamp the section count to 1..MAX_SECTIONS
  logic [5:0] n_sec;
  always_comb begin
    if (sections_q == 4'd0) begin
      n_sec = 6'd1;
    end else if (32'(sections_q) > MAX_SECTIONS) begin
      n_sec = 6'(MAX_SECTIONS);
    end else begin
      n_sec = {2'b00, sections_q};
    end
  end

  // ---- delays of the current section; an invalid row reads as zero
  logic signed [VAL_W-1:0] w1, w2;
  assign w1 = rd_valid_q ? drow_q[VAL_W-1:0]     : '0;
  assign w2 = rd_valid_q ? drow_q[ROW_W-1:VAL_W] : '0;

  // ---- multiplier operand: low half unsigned, high half signed
  logic signed [VAL_W-1:0]    mul_op;
  logic signed [HALF_W:0]     mul_b;
  logic signed [PROD_W-1:0]   mul_res;
  always_comb begin
    unique case (ctrl.mul_src)
      SRC_W0:  mul_op = w0_q;
      SRC_W1:  mul_op = w1;
      SRC_W2:  mul_op = w2;
      default: mul_op = '0;
    endcase
    mul_b   = ctrl.mul_hi ? {mul_op[VAL_W-1], mul_op[VAL_W-1:HALF_W]}
                          : {1'b0, mul_op[HALF_W-1:0]};
    mul_res = cdat_q * mul_b;
  end

  // ---- accumulator term, high-half products weighted by 2^20
  logic signed [ACC_W-1:0] acc_term, acc_sh;
  assign acc_term = prod_hi_q
                  ? {{(ACC_W-PROD_W-HALF_W){prod_q[PROD_W-1]}}, prod_q, {HALF_W{1'b0}}}
                  : {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_sh   = acc_q >>> COEF_FRAC_BITS;

  logic signed [ACC_W-1:0] fb_sum;
  assign fb_sum = acc_sh + ACC_W'(v_q);

  // ---- result: drop fraction toward zero, saturate to 16 bits
  logic signed [VAL_W:0]               v_round;
  logic signed [VAL_W-DLY_FRAC:0]      v_int;
  logic [SAMPLE_W-1:0]                 sample_res;
  always_comb begin
    v_round = (VAL_W+1)'(v_q) + (v_q[VAL_W-1] ? (VAL_W+1)'(17'h0FFFF) : '0);
    v_int   = v_round[VAL_W:DLY_FRAC];
    if ((&v_int[VAL_W-DLY_FRAC:SAMPLE_W-1]) || !(|v_int[VAL_W-DLY_FRAC:SAMPLE_W-1])) begin
      sample_res = v_int[SAMPLE_W-1:0];
    end else if (v_int[VAL_W-DLY_FRAC]) begin
      sample_res = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sample_res = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // ---- coefficient addresses
  logic [CA_W-1:0] caddr_wr, caddr_rd;
  assign caddr_wr = CA_W'(32'(in_csec) * COEFS_PER_SEC + 32'(in_cslot));
  assign caddr_rd = CA_W'(32'(sec_q) * COEFS_PER_SEC + 32'(ctrl.coef_slot));

  // ---- sequencer next state
  always_comb begin
    pc_d        = pc_q;
    sec_d       = sec_q;
    last_d      = last_q;
    sections_d  = cfg_wr ? pwdata[3:0] : sections_q;
    dvalid_d    = dvalid_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (ctrl.seq)
      SEQ_WAIT: begin
        if (in_fire && is_sample) begin
          pc_d   = PC_SEC;
          sec_d  = '0;
          last_d = SEC_W'(n_sec - 6'd1);
          if (in_op == OP_CLEAR) begin
            dvalid_d = '0;
          end
        end
      end
      SEQ_NEXT: pc_d = pc_q + 5'd1;
      SEQ_LOOP: begin
        dvalid_d[sec_q] = 1'b1;
        if (sec_q == last_q) begin
          pc_d = PC_EMIT;
        end else begin
          pc_d  = PC_SEC;
          sec_d = sec_q + 1'b1;
        end
      end
      SEQ_EMIT: begin
        if (emit_go) begin
          pc_d        = PC_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: pc_d = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_IDLE;
      sec_q       <= '0;
      last_q      <= '0;
      sections_q  <= 4'd1;
      dvalid_q    <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      sec_q       <= sec_d;
      last_q      <= last_d;
      sections_q  <= sections_d;
      dvalid_q    <= dvalid_d;
      out_valid_q <= out_valid_d;
      if (ctrl.dly_rd) begin
        rd_valid_q <= dvalid_q[sec_q];
      end
    end
  end

  // ---- datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire && is_sample) begin
      v_q <= {{(VAL_W-SAMPLE_W-DLY_FRAC){in_sample[SAMPLE_W-1]}}, in_sample,
              {DLY_FRAC{1'b0}}};
    end else if (ctrl.set_v) begin
      v_q <= sat_val(acc_sh);
    end
    if (ctrl.set_w0) begin
      w0_q <= sat_val(fb_sum);
    end
    if (ctrl.mul_en) begin
      prod_q    <= mul_res;
      prod_hi_q <= ctrl.mul_hi;
    end
    unique case (ctrl.acc_op)
      ACC_CLR:  acc_q <= '0;
      ACC_ADD:  acc_q <= acc_q + acc_term;
      ACC_SUB:  acc_q <= acc_q - acc_term;
      default:  acc_q <= acc_q;
    endcase
    if (emit_go) begin
      out_data_q <= sample_res;
    end
  end

  // ---- delay memory: one row per section, {w2, w1}
  always_ff @(posedge clk_i) begin
    if (ctrl.set_v) begin
      dly_mem[sec_q] <= {w1, w0_q};
    end
    if (ctrl.dly_rd) begin
      drow_q <= dly_mem[sec_q];
    end
  end

  // ---- coefficient memory
  always_ff @(posedge clk_i) begin
    if (in_fire && (in_op == OP_COEF) && coef_ok) begin
      coef_mem[caddr_wr] <= in_cval;
    end
    if (ctrl.coef_rd) begin
      cdat_q <= coef_mem[caddr_rd];
    end
  end

endmodule

### tb/sv/biquad_cascade_iir_filter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biquad_cascade_iir_filter_core_tb : self-checking bench for the biquad cascade
// Drives sample, clear-and-sample, coefficient and dropped beats through the
// input stream, sweeps sections_in_use over the APB port, and checks every
// output beat against a fixed-point model of the direct form II cascade.
// ----------------------------------------------------------------------------
module biquad_cascade_iir_filter_core_tb;
  import bqc_pkg::*;

  localparam int NUM_SEC     = 8;
  localparam int FRAC        = 16;
  // Worst-case run of one sample through all sections, plus some margin.
  localparam int SETTLE_CYC  = 15 * NUM_SEC + 2 + 20;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 1000;
  localparam int PHASE_BEATS = 212;

  localparam longint VAL_MAX     = 64'sd549755813887;
  localparam longint VAL_MIN     = -64'sd549755813888;
  localparam longint UNITY       = 65536;
  localparam longint A2_LIM      = 55705;   // |a2| <= 0.85
  localparam longint POLE_MARGIN = 62259;   // |a1| <= 0.95 + a2

  localparam logic [19:0] COEF_ONE = 20'h10000;
  localparam logic [19:0] COEF_MAX = 20'h7FFFF;
  localparam logic [19:0] COEF_MIN = 20'h80000;
  localparam logic [2:0]  SLOT_BAD_LO = 3'd5;
  localparam logic [2:0]  SLOT_BAD_HI = 3'd7;

  typedef struct packed {
    opcode_e            op;
    logic [2:0]         sec;
    logic [2:0]         slot;
    logic signed [19:0] cval;
    logic signed [15:0] smp;
  } beat_t;

  typedef struct packed {
    beat_t       beat;
    bit          known;   // expected output typed in the table
    logic [15:0] want;
  } row_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_e;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  always #5 clk_i = ~clk_i;

  biquad_cascade_iir_filter_core #(
    .MAX_SECTIONS  (NUM_SEC),
    .COEF_FRAC_BITS(FRAC)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // --------------------------------------------------------------------------
  // Cascade model state: coefficients, the two delays per section, the
  // section count, and the output samples still owed by the block.
  // --------------------------------------------------------------------------
  longint             coef_store [NUM_SEC*COEFS_PER_SEC];
  longint             dly_w1 [NUM_SEC];
  longint             dly_w2 [NUM_SEC];
  logic [3:0]         sections_reg;
  logic signed [15:0] samples_due [$];
  logic signed [15:0] want_sample;
  int                 fault_count  = 0;
  int                 results_seen = 0;
  int                 burst_left   = 0;
  int                 quiet_cycles = 0;
  int                 phase_sections [8] = '{0, 8, 15, 1, 2, 12, 5, 3};

  function automatic longint clamp_val(input longint x);
    if (x > VAL_MAX) return VAL_MAX;
    if (x < VAL_MIN) return VAL_MIN;
    return x;
  endfunction

  // Apply one accepted beat to the model; gives is set when a sample leaves.
  function automatic void run_cascade(input beat_t b, output bit gives,
                                      output logic signed [15:0] y);
    int     n;
    int     base;
    longint v, w0, w1, w2, fb, fw, q;
    gives = 1'b0;
    y     = '0;
    if (b.op == OP_COEF) begin
      // Slots past a2 hit nothing.
      if (b.slot <= SLOT_A2) begin
        coef_store[b.sec * COEFS_PER_SEC + b.slot] = longint'($signed(b.cval));
      end
      return;
    end
    if (b.op == OP_NONE) return;
    if (b.op == OP_CLEAR) begin
      for (int s = 0; s < NUM_SEC; s++) begin
        dly_w1[s] = 0;
        dly_w2[s] = 0;
      end
    end
    // Zero sections runs one; anything past the maximum runs all of them.
    n = sections_reg;
    if (n < 1) n = 1;
    if (n > NUM_SEC) n = NUM_SEC;
    v = longint'($signed(b.smp)) * UNITY;
    for (int s = 0; s < n; s++) begin
      base = s * COEFS_PER_SEC;
      w1   = dly_w1[s];
      w2   = dly_w2[s];
      fb   = -(coef_store[base + SLOT_A1] * w1) - coef_store[base + SLOT_A2] * w2;
      w0   = clamp_val(v + (fb >>> FRAC));
      fw   = coef_store[base + SLOT_B0] * w0 + coef_store[base + SLOT_B1] * w1 +
             coef_store[base + SLOT_B2] * w2;
      v    = clamp_val(fw >>> FRAC);
      dly_w2[s] = w1;
      dly_w1[s] = w0;
    end
    // Drop the fraction toward zero, then clamp to a 16-bit sample.
    q = (v < 0) ? -((-v) >>> FRAC) : (v >>> FRAC);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    gives = 1'b1;
    y     = q[15:0];
  endfunction

  // Pick a coefficient: forward gains in -1.0..1.0, feedback terms that keep
  // the section's poles inside the unit circle, given the other feedback term
  // already loaded; now and then (when allowed) an extreme or fully random one.
  function automatic logic [19:0] pick_coef(input logic [2:0] sec,
                                            input logic [2:0] slot, input bit wild_ok);
    longint lo, hi, a;
    int     base;
    base = sec * COEFS_PER_SEC;
    if (wild_ok && $urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 2))
        0:       return COEF_MAX;
        1:       return COEF_MIN;
        default: return 20'($urandom());
      endcase
    end
    lo = -UNITY;
    hi = UNITY;
    if (slot == SLOT_A2) begin
      a  = coef_store[base + SLOT_A1];
      if (a < 0) a = -a;
      lo = a - POLE_MARGIN;
      if (lo < -A2_LIM) lo = -A2_LIM;
      if (lo > A2_LIM) lo = A2_LIM;
      hi = A2_LIM;
    end else if (slot == SLOT_A1) begin
      a  = coef_store[base + SLOT_A2];
      if (a > A2_LIM) a = A2_LIM;
      if (a < -A2_LIM) a = -A2_LIM;
      hi = POLE_MARGIN + a;
      if (hi < 0) hi = 0;
      lo = -hi;
    end
    return 20'(lo + longint'($urandom_range(0, 32'(hi - lo))));
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1, 2:    return 16'($urandom_range(0, 4000) - 2000);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic row_t mk_row(input opcode_e op, input logic [15:0] smp,
                                  input logic [2:0] sec, input logic [2:0] slot,
                                  input logic [19:0] cval, input bit known,
                                  input logic [15:0] want);
    row_t r;
    r.beat.op   = op;
    r.beat.smp  = smp;
    r.beat.sec  = sec;
    r.beat.slot = slot;
    r.beat.cval = cval;
    r.known     = known;
    r.want      = want;
    return r;
  endfunction

  // Mostly samples; coefficient rewrites keep the filters moving, while
  // bad-slot writes and the dropped opcode are noise that does not count.
  task automatic random_item(output beat_t b, output bit counted);
    int r;
    r       = $urandom_range(0, 99);
    b.smp   = pick_sample();
    b.sec   = 3'($urandom());
    b.slot  = 3'($urandom());
    b.cval  = 20'($urandom());
    counted = 1'b1;
    if (r < 6) begin
      b.op = OP_CLEAR;
    end else if (r < 84) begin
      b.op = OP_SAMPLE;
    end else if (r < 95) begin
      b.op   = OP_COEF;
      b.slot = 3'($urandom_range(SLOT_B0, SLOT_A2));
      b.cval = pick_coef(b.sec, b.slot, 1'b1);
    end else if (r < 98) begin
      b.op    = OP_COEF;
      b.slot  = 3'($urandom_range(SLOT_BAD_LO, SLOT_BAD_HI));
      counted = 1'b0;
    end else begin
      b.op    = OP_NONE;
      counted = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side. Offer one beat, in bursts of random length separated by
  // random gaps; run the model on the beat once it is taken.
  // --------------------------------------------------------------------------
  task automatic send_beat(input beat_t b, input bit known, input logic [15:0] want);
    bit                 gives;
    logic signed [15:0] y;
    @(negedge clk_i);
    if (burst_left == 0) begin
      // Drop valid for a gap and scribble over the idle bus.
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 48'({$urandom(), $urandom()});
      s_axis_tuser  <= 2'($urandom());
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 6))
        @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, b.cval, b.slot, b.sec, b.smp};
    s_axis_tuser  <= b.op;
    do @(posedge clk_i); while (!s_axis_tready);
    run_cascade(b, gives, y);
    if (gives) samples_due.push_back(known ? want : y);
  endtask

  // Drop valid, wait for every owed sample, then let the sequencer run dry.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // APB write of sections_in_use, then a read back of the same register.
  task automatic write_sections(input logic [3:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ADDR_SECTIONS;
    pwdata  <= {28'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sections_reg = val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {28'd0, val}) begin
      $display("%0t: sections_in_use read back: expected %0d, actual %0d",
               $time, val, prdata);
      fault_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Output side. Stall on a pattern that changes after a random span (always
  // open, random, or one beat at a random regular period); twice in the run hold
  // off for a long stretch so the core fills up and stalls its input.
  // --------------------------------------------------------------------------
  initial begin : rx_side
    rx_mode_e mode;
    int       span;
    int       period;
    int       tick;
    int       hold_at;
    bit       rdy;
    mode    = RX_OPEN;
    span    = 0;
    period  = 1;
    tick    = 0;
    hold_at = 150;
    forever begin
      @(negedge clk_i);
      if (results_seen >= hold_at) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_at = hold_at + 900;
      end else begin
        if (span == 0) begin
          mode   = rx_mode_e'($urandom_range(0, 2));
          span   = $urandom_range(30, 400);
          period = $urandom_range(2, 9);
        end
        span--;
        tick++;
        case (mode)
          RX_OPEN:   rdy = 1'b1;
          RX_RANDOM: rdy = ($urandom_range(0, 3) != 0);
          default:   rdy = ((tick % period) == 0);
        endcase
        m_axis_tready <= rdy;
      end
    end
  end

  // Compare each output beat with the oldest owed sample.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (samples_due.size() == 0) begin
        $display("%0t: output beat with nothing owed: expected none, actual %0d",
                 $time, $signed(m_axis_tdata));
        fault_count <= fault_count + 1;
      end else begin
        want_sample = samples_due.pop_front();
        if (m_axis_tdata !== want_sample) begin
          $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                   $time, want_sample, $signed(m_axis_tdata));
          fault_count <= fault_count + 1;
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on any port for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed table, full coefficient load, then one random phase
  // per section count.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    row_t    rows [$];
    beat_t   b;
    bit      counted;
    int      n_counted;
    slot_e   load_order [5];
    for (int i = 0; i < NUM_SEC * COEFS_PER_SEC; i++) coef_store[i] = 0;
    for (int s = 0; s < NUM_SEC; s++) begin
      dly_w1[s] = 0;
      dly_w2[s] = 0;
    end
    sections_reg = 4'd1;
    // Load a2 ahead of a1 so the a1 bound sees the new a2.
    load_order[0] = SLOT_B0;
    load_order[1] = SLOT_B1;
    load_order[2] = SLOT_B2;
    load_order[3] = SLOT_A2;
    load_order[4] = SLOT_A1;

    // Pass-through section 0: the sample comes straight back.
    rows.push_back(mk_row(OP_COEF, 16'h0000, 3'd0, SLOT_B0, COEF_ONE, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_COEF, 16'h0000, 3'd0, SLOT_B1, 20'h00000, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_COEF, 16'h0000, 3'd0, SLOT_B2, 20'h00000, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_COEF, 16'h0000, 3'd0, SLOT_A1, 20'h00000, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_COEF, 16'h0000, 3'd0, SLOT_A2, 20'h00000, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_SAMPLE, 16'h7FFF, 3'd7, SLOT_BAD_HI, COEF_MAX, 1'b1, 16'h7FFF));
    rows.push_back(mk_row(OP_SAMPLE, 16'h8000, 3'd0, SLOT_B0, COEF_MIN, 1'b1, 16'h8000));
    rows.push_back(mk_row(OP_SAMPLE, 16'h0000, 3'd0, SLOT_B0, 20'h00000, 1'b1, 16'h0000));
    rows.push_back(mk_row(OP_SAMPLE, 16'hFFFF, 3'd5, SLOT_A1, 20'hFFFFF, 1'b1, 16'hFFFF));
    // Dropped opcode and writes past a2 leave the filter as it was.
    rows.push_back(mk_row(OP_NONE, 16'h1234, 3'd7, SLOT_BAD_HI, COEF_MAX, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_COEF, 16'h0000, 3'd0, SLOT_BAD_LO, COEF_MIN, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_COEF, 16'h0000, 3'd7, SLOT_BAD_HI, COEF_MAX, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_SAMPLE, 16'h0001, 3'd0, SLOT_B0, 20'h00000, 1'b1, 16'h0001));
    // b1 = 1.0 adds the previous sample: output saturates at both ends.
    rows.push_back(mk_row(OP_COEF, 16'h0000, 3'd0, SLOT_B1, COEF_ONE, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_SAMPLE, 16'h7FFF, 3'd0, SLOT_B0, 20'h00000, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_CLEAR, 16'h8000, 3'd0, SLOT_B0, 20'h00000, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_SAMPLE, 16'h8000, 3'd0, SLOT_B0, 20'h00000, 1'b0, 16'h0000));
    // Extreme forward gains; a small negative input checks truncation.
    rows.push_back(mk_row(OP_COEF, 16'h0000, 3'd0, SLOT_B0, COEF_MAX, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_COEF, 16'h0000, 3'd0, SLOT_B2, COEF_MIN, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_SAMPLE, 16'h0003, 3'd0, SLOT_B0, 20'h00000, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_SAMPLE, 16'hFFFD, 3'd0, SLOT_B0, 20'h00000, 1'b0, 16'h0000));
    // Runaway feedback drives the 16-bit output into saturation; clear recovers.
    rows.push_back(mk_row(OP_COEF, 16'h0000, 3'd0, SLOT_A1, COEF_MIN, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_COEF, 16'h0000, 3'd0, SLOT_A2, COEF_MAX, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_SAMPLE, 16'h7FFF, 3'd0, SLOT_B0, 20'h00000, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_SAMPLE, 16'h7FFF, 3'd0, SLOT_B0, 20'h00000, 1'b0, 16'h0000));
    rows.push_back(mk_row(OP_CLEAR, 16'h0005, 3'd0, SLOT_B0, 20'h00000, 1'b0, 16'h0000));

    // Hold reset at the start, then release it away from the rising edge.
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part runs on the reset value of one section.
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].known, rows[i].want);
    settle();

    // Load every coefficient of every section before more sections run.
    for (int s = 0; s < NUM_SEC; s++) begin
      for (int k = 0; k < COEFS_PER_SEC; k++) begin
        b.op   = OP_COEF;
        b.sec  = 3'(s);
        b.slot = load_order[k];
        b.cval = pick_coef(b.sec, b.slot, 1'b0);
        b.smp  = 16'($urandom());
        send_beat(b, 1'b0, 16'h0000);
      end
    end
    settle();

    foreach (phase_sections[p]) begin
      write_sections(4'(phase_sections[p]));
      n_counted = 0;
      while (n_counted < PHASE_BEATS) begin
        random_item(b, counted);
        send_beat(b, 1'b0, 16'h0000);
        if (counted) n_counted++;
      end
      settle();
    end

    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
